// ===== sv/necir_pkg.sv =====
// Package with the shared types and constants of the NEC infrared pulse decoder.
`default_nettype none
package necir_pkg;

  // Width of the stored code word and of the bit counter.
  localparam int WORD_BITS  = 32;
  localparam int COUNT_BITS = 6;

  // Interval windows in microseconds.
  localparam logic [15:0] LEAD_MIN      = 16'd8000;
  localparam logic [15:0] LEAD_LIMIT    = 16'd10000;
  localparam logic [15:0] HDR_MIN       = 16'd3500;
  localparam logic [15:0] HDR_MAX       = 16'd5500;
  localparam logic [15:0] SHORT_FLOOR   = 16'd400;
  localparam logic [15:0] SHORT_LIMIT   = 16'd750;
  localparam logic [15:0] LONG_FLOOR    = 16'd1500;
  localparam logic [15:0] LONG_LIMIT    = 16'd1700;
  localparam logic [15:0] REP_FLOOR     = 16'd1700;
  localparam logic [15:0] REP_LIMIT     = 16'd2800;

  // Depth of the queue between the classifier and the decoder.
  localparam int QUEUE_DEPTH = 2;

  // Result codes.
  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_REPEAT = 2'd1,
    KIND_ERROR  = 2'd2
  } event_kind_t;

  // Window flags found by the classifier for one edge.
  typedef struct packed {
    logic lead;      // mark of 8000 up to 9999 us
    logic hdr;       // space of 3500 to 5500 us
    logic short_hi;  // space of 401 to 749 us
    logic long_hi;   // space of 1501 to 1699 us
    logic rep_hi;    // space of 1701 to 2799 us
    logic short_lo;  // mark of 401 to 749 us
    logic lo_nz;     // mark of nonzero length
  } class_t;

  // One queue entry: flags plus the raw interval for error reports.
  typedef struct packed {
    class_t      cls;
    logic [15:0] interval;
  } entry_t;

endpackage
`default_nettype wire

// ===== sv/necir_if.sv =====
// Valid/ready channel interfaces for the edge input and the event output.
`default_nettype none
interface necir_in_if;
  logic        valid;
  logic        ready;
  logic        line_level;
  logic [15:0] interval_us;

  modport source (output valid, output line_level, output interval_us, input ready);
  modport sink   (input valid, input line_level, input interval_us, output ready);
endinterface

interface necir_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  event_kind;
  logic [7:0]  addr_low;
  logic [7:0]  addr_high;
  logic [7:0]  cmd_byte;
  logic [7:0]  cmd_check;
  logic [7:0]  repeat_total;
  logic [15:0] error_interval;
  logic [5:0]  error_bits;

  modport source (output valid, output event_kind, output addr_low, output addr_high,
                  output cmd_byte, output cmd_check, output repeat_total,
                  output error_interval, output error_bits, input ready);
  modport sink   (input valid, input event_kind, input addr_low, input addr_high,
                  input cmd_byte, input cmd_check, input repeat_total,
                  input error_interval, input error_bits, output ready);
endinterface
`default_nettype wire

// ===== sv/necir_front.sv =====
// Front end: accepts edges and sorts the interval into its timing windows.
`default_nettype none
module necir_front import necir_pkg::*; (
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_line_level,
  input  wire logic [15:0] in_interval_us,
  output logic             push_valid,
  input  wire logic        push_ready,
  output entry_t           push_entry
);

  logic [15:0] hi_us;
  logic [15:0] lo_us;

  // Split the interval into a space (high) or mark (low) length.
  assign hi_us = in_line_level ? 16'd0 : in_interval_us;
  assign lo_us = in_line_level ? in_interval_us : 16'd0;

  // Window compares.
  always_comb begin
    push_entry.interval     = in_interval_us;
    push_entry.cls.lead     = (lo_us >= LEAD_MIN) && (lo_us < LEAD_LIMIT);
    push_entry.cls.hdr      = (hi_us >= HDR_MIN) && (hi_us <= HDR_MAX);
    push_entry.cls.short_hi = (hi_us > SHORT_FLOOR) && (hi_us < SHORT_LIMIT);
    push_entry.cls.long_hi  = (hi_us > LONG_FLOOR) && (hi_us < LONG_LIMIT);
    push_entry.cls.rep_hi   = (hi_us > REP_FLOOR) && (hi_us < REP_LIMIT);
    push_entry.cls.short_lo = (lo_us > SHORT_FLOOR) && (lo_us < SHORT_LIMIT);
    push_entry.cls.lo_nz    = (lo_us != 16'd0);
  end

  // A transaction is taken whenever the queue has room.
  assign push_valid = in_valid;
  assign in_ready   = push_ready;

endmodule
`default_nettype wire

// ===== sv/necir_queue.sv =====
// Small register queue between the classifier and the decoder.
`default_nettype none
module necir_queue import necir_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push_valid,
  output logic        push_ready,
  input  wire entry_t push_entry,
  output logic        pop_valid,
  input  wire logic   pop_ready,
  output entry_t      pop_entry
);

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  entry_t                slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_BITS-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign push_ready = (count_r != CNT_BITS'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule
`default_nettype wire

// ===== sv/necir_back.sv =====
// Back end: protocol state, code word assembly and the output register.
`default_nettype none
module necir_back import necir_pkg::*; #(
  parameter int CODE_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   pop_valid,
  output logic        pop_ready,
  input  wire entry_t pop_entry,
  necir_out_if.source out_ch
);

  logic                  lead_r, lead_nxt;
  logic                  header_r, header_nxt;
  logic                  mark_r, mark_nxt;
  logic                  rep_space_r, rep_space_nxt;
  logic [COUNT_BITS-1:0] bit_count_r, bit_count_nxt;
  logic [CODE_BITS-1:0]  code_r, code_nxt;
  logic [7:0]            rep_count_r, rep_count_nxt;

  logic                  out_valid_r, out_valid_nxt;
  event_kind_t           kind_r, kind_nxt;
  logic [WORD_BITS-1:0]  word_r, word_nxt;
  logic [7:0]            rep_out_r, rep_out_nxt;
  logic [15:0]           err_iv_r, err_iv_nxt;
  logic [5:0]            err_bits_r, err_bits_nxt;

  logic                  do_pop;
  logic                  handled;
  logic                  emit;
  logic                  count_full;
  class_t                c;

  // An entry is taken when the output slot is free or being emptied.
  assign pop_ready  = !out_valid_r || out_ch.ready;
  assign do_pop     = pop_valid && pop_ready;
  assign c          = pop_entry.cls;
  assign count_full = (int'(bit_count_r) >= CODE_BITS);

  // Decode one edge against the current state.
  always_comb begin
    lead_nxt      = lead_r;
    header_nxt    = header_r;
    mark_nxt      = mark_r;
    rep_space_nxt = rep_space_r;
    bit_count_nxt = bit_count_r;
    code_nxt      = code_r;
    rep_count_nxt = rep_count_r;
    emit          = 1'b0;
    handled       = 1'b0;
    kind_nxt      = KIND_ERROR;
    word_nxt      = '0;
    rep_out_nxt   = '0;
    err_iv_nxt    = '0;
    err_bits_nxt  = '0;

    if (c.lead) begin
      lead_nxt   = 1'b1;
      header_nxt = 1'b0;
      handled    = 1'b1;
    end else if (lead_r && !header_r && c.hdr) begin
      header_nxt    = 1'b1;
      lead_nxt      = 1'b0;
      bit_count_nxt = '0;
      code_nxt      = '0;
      rep_count_nxt = '0;
      handled       = 1'b1;
    end else if (header_r) begin
      if (c.short_hi && mark_r) begin
        mark_nxt      = 1'b0;
        bit_count_nxt = bit_count_r + 1'b1;
        handled       = 1'b1;
      end else if (c.long_hi) begin
        // A long space without a preceding mark is dropped quietly.
        if (mark_r) begin
          mark_nxt      = 1'b0;
          bit_count_nxt = bit_count_r + 1'b1;
          for (int i = 0; i < CODE_BITS; i++) begin
            if (int'(bit_count_r) == i) begin
              code_nxt[i] = 1'b1;
            end
          end
        end
        handled = 1'b1;
      end else if (c.short_lo) begin
        mark_nxt = 1'b1;
        handled  = 1'b1;
        if (count_full) begin
          bit_count_nxt = bit_count_r + 1'b1;
          header_nxt    = 1'b0;
          emit          = 1'b1;
          kind_nxt      = KIND_FRAME;
          word_nxt      = WORD_BITS'(code_r);
        end
      end
    end

    // Repeat code handling after a lead.
    if (!handled && lead_r) begin
      if (c.rep_hi) begin
        rep_space_nxt = 1'b1;
        handled       = 1'b1;
      end else if (rep_space_r && c.short_lo) begin
        lead_nxt      = 1'b0;
        rep_count_nxt = rep_count_r + 1'b1;
        emit          = 1'b1;
        handled       = 1'b1;
        kind_nxt      = KIND_REPEAT;
        rep_out_nxt   = rep_count_r + 1'b1;
      end
    end

    // Any other nonzero mark is reported.
    if (!handled && c.lo_nz) begin
      emit         = 1'b1;
      kind_nxt     = KIND_ERROR;
      err_iv_nxt   = pop_entry.interval;
      err_bits_nxt = bit_count_r;
    end

    if (do_pop) begin
      out_valid_nxt = emit;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Control and protocol state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r      <= 1'b0;
      header_r    <= 1'b0;
      mark_r      <= 1'b0;
      rep_space_r <= 1'b0;
      bit_count_r <= '0;
      code_r      <= '0;
      rep_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (do_pop) begin
        lead_r      <= lead_nxt;
        header_r    <= header_nxt;
        mark_r      <= mark_nxt;
        rep_space_r <= rep_space_nxt;
        bit_count_r <= bit_count_nxt;
        code_r      <= code_nxt;
        rep_count_r <= rep_count_nxt;
      end
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (do_pop && emit) begin
      kind_r     <= kind_nxt;
      word_r     <= word_nxt;
      rep_out_r  <= rep_out_nxt;
      err_iv_r   <= err_iv_nxt;
      err_bits_r <= err_bits_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.event_kind     = kind_r;
  assign out_ch.addr_low       = word_r[7:0];
  assign out_ch.addr_high      = word_r[15:8];
  assign out_ch.cmd_byte       = word_r[23:16];
  assign out_ch.cmd_check      = word_r[31:24];
  assign out_ch.repeat_total   = rep_out_r;
  assign out_ch.error_interval = err_iv_r;
  assign out_ch.error_bits     = err_bits_r;

endmodule
`default_nettype wire

// ===== sv/nec_ir_pulse_decoder_unit.sv =====
// An accepted edge is held in the queue, then decoded into the registered output slot.
// Throughput: one edge per cycle unless an output result is waiting untaken; the decoder state updates per edge.
// The two-entry queue and the output register let input and output stall on their own.
// Reset (rst_n low, synchronous) clears the decoder state, the queue and the output valid.
// The output payload register is not reset and is only read while valid is high.
`default_nettype none
module nec_ir_pulse_decoder_unit import necir_pkg::*; #(
  parameter int CODE_BITS = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  necir_in_if.sink    in_ch,
  necir_out_if.source out_ch
);

  logic   push_valid;
  logic   push_ready;
  entry_t push_entry;
  logic   pop_valid;
  logic   pop_ready;
  entry_t pop_entry;

  // Classify each incoming transaction.
  necir_front u_front (
    .in_valid       (in_ch.valid),
    .in_ready       (in_ch.ready),
    .in_line_level  (in_ch.line_level),
    .in_interval_us (in_ch.interval_us),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_entry     (push_entry)
  );

  // Decouple the classifier from the decoder.
  necir_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // Protocol decoding and result output.
  necir_back #(
    .CODE_BITS (CODE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire
